// ===== src/bzc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzc_pkg: shared types and constants for the Bezier point evaluator
// Sizes, fixed-point format, binomial table and the control words that the
// top level hands to the row of cells.
// ----------------------------------------------------------------------------
package bzc_pkg;

  localparam int MAX_POINTS = 8;
  localparam int COORD_BITS = 10;
  localparam int NP_W       = 4;    // num_points register width
  localparam int PIDX_W     = 3;    // point_index width
  localparam int Q_FRAC     = 16;
  localparam int Q_W        = Q_FRAC + 1;  // Q0.16 plus the 1.0 bit
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int BINOM_W    = MAX_POINTS;  // C(n-1,k) <= 2^(n-1)
  localparam int W_W        = Q_W + BINOM_W;
  localparam int PROD_W     = W_W + COORD_BITS;
  localparam int TERM_W     = PROD_W - Q_FRAC;
  localparam int SUM_W      = TERM_W + IDX_W;
  // counter value at which the last partial sum is stable
  localparam int SETTLE     = 2 * MAX_POINTS + 3;
  localparam int CNT_W      = $clog2(SETTLE + 1);

  localparam logic [Q_W-1:0]        Q_ONE      = Q_W'(1) << Q_FRAC;
  localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] binom_tab_t;

  // Pascal's triangle, row r holds C(r,k)
  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int r = 0; r < MAX_POINTS; r++) begin
      tab[r][0] = BINOM_W'(1);
      for (int k = 1; k <= r; k++) begin
        tab[r][k] = tab[r-1][k-1] + tab[r-1][k];
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = build_binom();

  typedef struct packed {
    logic [Q_W-1:0]   t;
    logic [Q_W-1:0]   u;
    logic [IDX_W-1:0] last;   // curve degree, index of last point in use
  } bzc_ctl_t;

  typedef struct packed {
    logic                  we;
    logic [PIDX_W-1:0]     idx;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } bzc_load_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } bzc_state_t;

endpackage

// ===== src/bzc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzc_cell: one control point slot of the Bezier evaluator
// Holds one point, builds t^i from its left neighbor and (1-t)^(r-i) from its
// right neighbor, forms its weighted term and adds it to the partial sum
// coming from the left.
// ----------------------------------------------------------------------------
module bzc_cell import bzc_pkg::*; (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     cell_idx,
  input  bzc_ctl_t             ctl,
  input  bzc_load_t            load,
  input  logic [Q_W-1:0]       tp_in,
  output logic [Q_W-1:0]       tp_out,
  input  logic [Q_W-1:0]       up_in,
  output logic [Q_W-1:0]       up_out,
  input  logic [SUM_W-1:0]     psum_x_in,
  input  logic [SUM_W-1:0]     psum_y_in,
  output logic [SUM_W-1:0]     psum_x_out,
  output logic [SUM_W-1:0]     psum_y_out
);

  logic [COORD_BITS-1:0] px_r, py_r;
  logic [Q_W-1:0]        tp_r, tp_nxt;
  logic [Q_W-1:0]        up_r, up_nxt;
  logic [Q_W-1:0]        basis_r, basis_nxt;
  logic [W_W-1:0]        w_r, w_nxt;
  logic [TERM_W-1:0]     term_x_r, term_x_nxt;
  logic [TERM_W-1:0]     term_y_r, term_y_nxt;
  logic [SUM_W-1:0]      psum_x_r, psum_x_nxt;
  logic [SUM_W-1:0]      psum_y_r, psum_y_nxt;

  logic [2*Q_W-1:0]      tp_prod, up_prod, basis_prod;
  logic [PROD_W-1:0]     tx_prod, ty_prod;
  logic                  active;
  logic                  wr_hit;

  assign active = (cell_idx <= ctl.last);
  assign wr_hit = load.we && (NP_W'(load.idx) == NP_W'(cell_idx));

  // products handed to the neighbors, truncated back to Q1.16
  assign tp_prod = (2*Q_W)'(tp_r) * (2*Q_W)'(ctl.t);
  assign up_prod = (2*Q_W)'(up_r) * (2*Q_W)'(ctl.u);
  assign tp_out  = tp_prod[Q_FRAC +: Q_W];
  assign up_out  = up_prod[Q_FRAC +: Q_W];

  assign basis_prod = (2*Q_W)'(up_r) * (2*Q_W)'(tp_r);
  assign tx_prod    = PROD_W'(w_r) * PROD_W'(px_r);
  assign ty_prod    = PROD_W'(w_r) * PROD_W'(py_r);

  always_comb begin
    tp_nxt     = tp_in;
    up_nxt     = (cell_idx == ctl.last) ? Q_ONE : up_in;
    basis_nxt  = basis_prod[Q_FRAC +: Q_W];
    w_nxt      = W_W'(BINOM_TAB[ctl.last][cell_idx]) * W_W'(basis_r);
    term_x_nxt = active ? tx_prod[PROD_W-1:Q_FRAC] : '0;
    term_y_nxt = active ? ty_prod[PROD_W-1:Q_FRAC] : '0;
    psum_x_nxt = psum_x_in + SUM_W'(term_x_r);
    psum_y_nxt = psum_y_in + SUM_W'(term_y_r);
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      px_r <= load.x;
      py_r <= load.y;
    end
    tp_r     <= tp_nxt;
    up_r     <= up_nxt;
    basis_r  <= basis_nxt;
    w_r      <= w_nxt;
    term_x_r <= term_x_nxt;
    term_y_r <= term_y_nxt;
    psum_x_r <= psum_x_nxt;
    psum_y_r <= psum_y_nxt;
  end

  assign psum_x_out = psum_x_r;
  assign psum_y_out = psum_y_r;

endmodule

// ===== src/bezier_curve_point_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_point_eval: Bernstein-form Bezier curve point evaluator
// Loads up to MAX_POINTS control points and evaluates the curve at t (Q1.16).
// ----------------------------------------------------------------------------
// A load word writes one control point and returns nothing. An evaluate word
// returns one curve point: the powers of t and 1-t ripple one cell per cycle
// through a row of MAX_POINTS cells, then three multiply stages form each
// term and the partial sum ripples along the row from left to right. One
// evaluation runs at a time; loads and evaluations are taken again as soon
// as the result sits in the output register, even while that register is
// stalled. The user must write num_points through the cfg port only while
// the block is idle; the block itself does not enforce this. 0 acts as 1
// and values above MAX_POINTS act as MAX_POINTS.
module bezier_curve_point_eval import bzc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [PIDX_W-1:0]     in_point_index,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic [Q_W-1:0]        in_t_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_curve_x,
  output logic [COORD_BITS-1:0] out_curve_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [NP_W-1:0]       cfg_data
);

  bzc_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [NP_W-1:0]       num_points_r;
  bzc_ctl_t              ctl_r;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;

  logic                  in_acc;
  logic                  eval_start;
  logic                  done;
  bzc_load_t             load;
  logic [NP_W-1:0]       n_use;
  logic [Q_W-1:0]        t_sat;

  logic [Q_W-1:0]        tp_link     [MAX_POINTS+1];
  logic [Q_W-1:0]        up_link     [MAX_POINTS+1];
  logic [SUM_W-1:0]      psum_x_link [MAX_POINTS+1];
  logic [SUM_W-1:0]      psum_y_link [MAX_POINTS+1];
  logic [SUM_W-1:0]      sum_x, sum_y;

  assign in_acc     = in_valid && !in_stall;
  assign eval_start = in_acc && (in_func == FUNC_EVAL);
  assign done       = (state_r == ST_EVAL) && (cnt_r == CNT_W'(SETTLE))
                      && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (eval_start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
    load.we   = in_acc && (in_func == FUNC_LOAD);
    load.idx  = in_point_index;
    load.x    = in_point_x;
    load.y    = in_point_y;
  end

  always_comb begin
    if (num_points_r == '0) begin
      n_use = NP_W'(1);
    end else if (num_points_r > NP_W'(MAX_POINTS)) begin
      n_use = NP_W'(MAX_POINTS);
    end else begin
      n_use = num_points_r;
    end
    t_sat = (in_t_value > Q_ONE) ? Q_ONE : in_t_value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (eval_start) begin
      cnt_nxt = '0;
    end else if (state_r == ST_EVAL && cnt_r != CNT_W'(SETTLE)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      num_points_r <= NP_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) num_points_r <= cfg_data;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // evaluation operands and result word
  always_ff @(posedge clk) begin
    if (eval_start) begin
      ctl_r.t    <= t_sat;
      ctl_r.u    <= Q_ONE - t_sat;
      ctl_r.last <= IDX_W'(n_use - NP_W'(1));
    end
    if (done) begin
      out_x_r <= (sum_x > SUM_W'(COORD_MASK)) ? COORD_MASK : sum_x[COORD_BITS-1:0];
      out_y_r <= (sum_y > SUM_W'(COORD_MASK)) ? COORD_MASK : sum_y[COORD_BITS-1:0];
    end
  end

  assign tp_link[0]              = Q_ONE;
  assign up_link[MAX_POINTS]     = Q_ONE;
  assign psum_x_link[0]          = '0;
  assign psum_y_link[0]          = '0;
  assign sum_x                   = psum_x_link[MAX_POINTS];
  assign sum_y                   = psum_y_link[MAX_POINTS];

  // t powers and partial sums travel left to right, (1-t) powers right to left
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    bzc_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctl        (ctl_r),
      .load       (load),
      .tp_in      (tp_link[i]),
      .tp_out     (tp_link[i+1]),
      .up_in      (up_link[i+1]),
      .up_out     (up_link[i]),
      .psum_x_in  (psum_x_link[i]),
      .psum_y_in  (psum_y_link[i]),
      .psum_x_out (psum_x_link[i+1]),
      .psum_y_out (psum_y_link[i+1])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;

endmodule
